// File: hdl/sst_pkg.sv
// Shared types and constants for the sparse-set slot table.
package sst_pkg;

  localparam int HANDLE_W   = 8;
  localparam int COUNT_W    = 9;
  localparam int PAYLOAD_W  = 32;
  localparam int CAPACITY_DEF = 256;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] entry_data;
  } sst_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  result_handle;
    logic [HANDLE_W-1:0]  dense_index;
    logic                 found;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   live_count;
    logic [1:0]           status;
  } sst_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_UPDATE
  } sst_state_t;

  typedef struct packed {
    logic accept;
    logic create;
    logic fetch;
    logic remove;
    logic respond;
  } sst_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       out_free;
  } sst_sts_t;

endpackage

// File: hdl/sst_ctrl.sv
// Operation sequencer for the sparse-set slot table.
module sst_ctrl import sst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sst_sts_t sts_i,
  output sst_cmd_t cmd_o
);

  sst_state_t state_r, state_nxt;
  logic       is_probe;

  assign is_probe = (sts_i.mode == MODE_REMOVE) || (sts_i.mode == MODE_LOOKUP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (is_probe && sts_i.hit) begin
          cmd_o.fetch = 1'b1;
          state_nxt   = S_UPDATE;
        end else if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          cmd_o.create  = (sts_i.mode == MODE_CREATE);
          state_nxt     = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          cmd_o.remove  = (sts_i.mode == MODE_REMOVE);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/sst_dpath.sv
// Datapath: sparse map, dense arrays, free stack, counters and result register.
module sst_dpath import sst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sst_in_t  in_data,
  input  sst_cmd_t cmd_i,
  output sst_sts_t sts_o,
  output logic     out_valid,
  input  logic     out_ready,
  output sst_out_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [IDX_W-1:0]     sparse_pos_mem [CAPACITY];
  logic [IDX_W-1:0]     dense_hdl_mem  [CAPACITY];
  logic [PAYLOAD_W-1:0] dense_pay_mem  [CAPACITY];
  logic [IDX_W-1:0]     free_mem       [CAPACITY];

  logic [CAPACITY-1:0]  valid_r;
  logic [CNT_W-1:0]     count_r, free_top_r, next_fresh_r;
  sst_in_t              op_r;
  logic [IDX_W-1:0]     pos_rd_r, fs_rd_r, moved_r;
  logic [PAYLOAD_W-1:0] pay_a_r, pay_b_r;
  logic                 out_valid_r;
  sst_out_t             out_r, out_nxt;

  logic [IDX_W-1:0]     h_idx, ft_m1, last_idx, new_h, pos_new;
  logic                 h_ok, hit, full, use_stack, out_free, do_create, relocate;

  logic                 sp_we, dh_we, dp_we, fs_we;
  logic [IDX_W-1:0]     sp_wa, sp_wd, dh_wa, dh_wd, dp_wa;
  logic [PAYLOAD_W-1:0] dp_wd;

  assign h_idx     = op_r.handle[IDX_W-1:0];
  assign h_ok      = 32'(op_r.handle) < CAPACITY;
  assign ft_m1     = IDX_W'(free_top_r - CNT_W'(1));
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign hit       = h_ok && valid_r[h_idx] && (CNT_W'(pos_rd_r) < count_r);
  assign use_stack = free_top_r != '0;
  assign full      = (count_r >= CNT_W'(CAPACITY)) ||
                     (!use_stack && (next_fresh_r >= CNT_W'(CAPACITY)));
  assign new_h     = use_stack ? fs_rd_r : next_fresh_r[IDX_W-1:0];
  assign pos_new   = count_r[IDX_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign do_create = cmd_i.create && !full;
  assign relocate  = cmd_i.remove && (pos_rd_r != last_idx);

  assign sts_o.mode     = op_r.mode;
  assign sts_o.hit      = hit;
  assign sts_o.out_free = out_free;

  // write port selection
  always_comb begin
    sp_we = do_create || relocate;
    sp_wa = do_create ? new_h : moved_r;
    sp_wd = do_create ? pos_new : pos_rd_r;
    dh_we = do_create || relocate;
    dh_wa = do_create ? pos_new : pos_rd_r;
    dh_wd = do_create ? new_h : moved_r;
    dp_we = do_create || relocate;
    dp_wa = do_create ? pos_new : pos_rd_r;
    dp_wd = do_create ? op_r.entry_data : pay_b_r;
    fs_we = cmd_i.remove;
  end

  always_ff @(posedge clk) begin
    if (sp_we) sparse_pos_mem[sp_wa] <= sp_wd;
    if (dh_we) dense_hdl_mem[dh_wa] <= dh_wd;
    if (dp_we) dense_pay_mem[dp_wa] <= dp_wd;
    if (fs_we) free_mem[free_top_r[IDX_W-1:0]] <= h_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      op_r     <= in_data;
      pos_rd_r <= sparse_pos_mem[in_data.handle[IDX_W-1:0]];
      fs_rd_r  <= free_mem[ft_m1];
    end
    if (cmd_i.fetch) begin
      pay_a_r <= dense_pay_mem[pos_rd_r];
      pay_b_r <= dense_pay_mem[last_idx];
      moved_r <= dense_hdl_mem[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      free_top_r   <= '0;
      next_fresh_r <= '0;
    end else begin
      if (do_create) begin
        valid_r[new_h] <= 1'b1;
        count_r        <= count_r + CNT_W'(1);
        if (use_stack) begin
          free_top_r <= free_top_r - CNT_W'(1);
        end else begin
          next_fresh_r <= next_fresh_r + CNT_W'(1);
        end
      end
      if (cmd_i.remove) begin
        valid_r[h_idx] <= 1'b0;
        count_r        <= count_r - CNT_W'(1);
        free_top_r     <= free_top_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_nxt               = '0;
    out_nxt.result_handle = op_r.handle;
    out_nxt.live_count    = COUNT_W'(count_r);
    out_nxt.status        = ST_OK;
    case (op_r.mode) inside
      MODE_CREATE: begin
        if (full) begin
          out_nxt.result_handle = '0;
          out_nxt.status        = ST_FULL;
        end else begin
          out_nxt.result_handle = HANDLE_W'(new_h);
          out_nxt.dense_index   = HANDLE_W'(pos_new);
          out_nxt.found         = 1'b1;
          out_nxt.payload       = op_r.entry_data;
          out_nxt.live_count    = COUNT_W'(count_r + CNT_W'(1));
        end
      end
      MODE_REMOVE, MODE_LOOKUP: begin
        if (hit) begin
          out_nxt.dense_index = HANDLE_W'(pos_rd_r);
          out_nxt.found       = 1'b1;
          out_nxt.payload     = pay_a_r;
          if (op_r.mode == MODE_REMOVE) begin
            out_nxt.live_count = COUNT_W'(count_r - CNT_W'(1));
          end
        end else begin
          out_nxt.status = ST_INVALID;
        end
      end
      default: out_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.respond) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_handle_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_top_r} + {1'b0, count_r}) == {1'b0, next_fresh_r})
    else $error("free stack and live count do not account for issued handles");

  a_respond_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.respond |-> out_free)
    else $error("result overwritten before taken");

  a_respond_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.respond |=> out_valid_r)
    else $error("result beat not raised");

  a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.remove |-> (hit && count_r != '0))
    else $error("remove of a handle that is not live");

endmodule

// File: hdl/sparse_set_slot_table_top.sv
// Sparse-set slot table top level: sequencer plus datapath.
// Each beat is one operation: create appends an entry and hands back a handle (popped from
// the free stack, else freshly issued), remove swaps the last dense entry into the hole and
// frees the handle, lookup reports the dense position and payload. One operation is worked
// at a time: create, a missed handle and the unused mode pass S_IDLE, S_RESOLVE, S_IDLE; a hit
// on remove or lookup adds S_UPDATE, as the registered read of the sparse position is followed
// by the registered read of the dense arrays; the last state waits for a free output register.
// A finished result sits in an output register, so the next beat is taken while it waits. The
// valid bits of the sparse map live in flip-flops cleared by reset, so no clearing pass follows
// reset. CAPACITY ranges from 2 to 256.
module sparse_set_slot_table_top import sst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sst_out_t out_data
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  sst_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
